/* sv/ptd_pkg.sv */
// Shared types, widths and constants of the periodic tick task dispatcher.
package ptd_pkg;

    localparam int SLOT_COUNT_DEF = 8;

    localparam int RATE_W    = 15;
    localparam int PERIOD_W  = 24;
    localparam int HANDLER_W = 8;
    localparam int CONTEXT_W = 16;
    localparam int RELOAD_W  = 7;
    localparam int US_W      = 20;
    localparam int DSH_W     = 34;
    localparam int STEP_W    = 5;

    localparam int MASK_W    = 8;
    localparam int STATUS_W  = 3;
    localparam int SLOT_W    = 3;
    localparam int ACTIVE_W  = 4;

    localparam int S_DATA_W  = 48;
    localparam int M_DATA_W  = 16;
    localparam int ADDR_W    = 3;

    localparam int unsigned US_PER_SECOND = 1000000;
    localparam int unsigned RATE_RESET    = 2000;
    localparam int unsigned US_TICK_RESET = US_PER_SECOND / RATE_RESET;

    localparam logic [RELOAD_W-1:0] PERIOD_MAX    = 7'd127;
    localparam logic [STEP_W-1:0]   CFG_LAST_STEP = 5'd19;
    localparam logic [STEP_W-1:0]   REG_LAST_STEP = 5'd6;
    localparam logic [ADDR_W-1:0]   ADDR_TICK_RATE = 3'd0;

    localparam logic CMD_TICK     = 1'b0;
    localparam logic CMD_REGISTER = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_TICK       = 3'd0,
        ST_REGISTERED = 3'd1,
        ST_DUPLICATE  = 3'd2,
        ST_FULL       = 3'd3,
        ST_NULL       = 3'd4
    } status_t;

    typedef struct packed {
        logic tick;
        logic wr;
        logic active;
    } ptd_ctl_t;

    typedef struct packed {
        logic [HANDLER_W-1:0] handler;
        logic [CONTEXT_W-1:0] context_tag;
        logic [RELOAD_W-1:0]  reload;
    } ptd_key_t;

    typedef struct packed {
        logic start;
        logic done;
    } ptd_div_hs_t;

endpackage

/* sv/ptd_cell.sv */
// One task slot: stores the task, counts its period down and checks for duplicates.
module ptd_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  ptd_pkg::ptd_ctl_t ctl,
    input  ptd_pkg::ptd_key_t key,
    input  logic [ptd_pkg::RELOAD_W-1:0] wr_counter,
    input  logic              hit_in,
    output logic              hit_out,
    output logic              fire
);
    import ptd_pkg::*;

    logic [HANDLER_W-1:0] handler_reg;
    logic [CONTEXT_W-1:0] context_reg;
    logic [RELOAD_W-1:0]  reload_reg;
    logic [RELOAD_W-1:0]  counter_reg;
    logic                 hit_reg;
    logic                 due;
    logic                 match;

    assign due   = (counter_reg <= RELOAD_W'(1));
    assign fire  = ctl.tick & ctl.active & due;
    assign match = ctl.active & (handler_reg == key.handler)
                 & (context_reg == key.context_tag) & (reload_reg == key.reload);
    assign hit_out = hit_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr) begin
            handler_reg <= key.handler;
            context_reg <= key.context_tag;
            reload_reg  <= key.reload;
            counter_reg <= wr_counter;
        end else if (ctl.tick && ctl.active) begin
            counter_reg <= due ? reload_reg : counter_reg - RELOAD_W'(1);
        end
    end

    // pass the match flag one slot along per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
        end else begin
            hit_reg <= hit_in | match;
        end
    end

endmodule

/* sv/ptd_div.sv */
// Restoring serial divider, one quotient bit per cycle.
module ptd_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [ptd_pkg::PERIOD_W-1:0]  dividend,
    input  logic [ptd_pkg::DSH_W-1:0]     dsh_init,
    input  logic [ptd_pkg::STEP_W-1:0]    last_step,
    output logic                          done,
    output logic [ptd_pkg::US_W-1:0]      quotient
);
    import ptd_pkg::*;

    logic [PERIOD_W-1:0] rem_reg;
    logic [DSH_W-1:0]    dsh_reg;
    logic [US_W-1:0]     quo_reg;
    logic [STEP_W-1:0]   cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic                ge;

    assign ge       = {{(DSH_W-PERIOD_W){1'b0}}, rem_reg} >= dsh_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                rem_reg  <= dividend;
                dsh_reg  <= dsh_init;
                quo_reg  <= '0;
                cnt_reg  <= last_step;
            end else if (busy_reg) begin
                rem_reg <= ge ? rem_reg - dsh_reg[PERIOD_W-1:0] : rem_reg;
                quo_reg <= {quo_reg[US_W-2:0], ge};
                dsh_reg <= dsh_reg >> 1;
                cnt_reg <= cnt_reg - STEP_W'(1);
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

/* sv/periodic_tick_task_dispatcher_top.sv */
// Top level of the periodic tick task dispatcher: control, divider and slot row.
//
//  channel  | ports                      | beat contents
//  ---------+----------------------------+-------------------------------------------
//  input    | s_tvalid s_tready s_tdata  | tuser cmd; tdata period, handler, context
//  result   | m_tvalid m_tready m_tdata  | tuser status; tdata mask, slot, count
//  config   | psel penable pwrite paddr  | tick_rate_hz at address 0
//
//  Tick beat: at the accept edge the slot row decrements every active counter and reloads those that are due.
//  Register beat: divider (7 quotient bits), match chain scan over the slot row, then the decision once output is free.
//  Tick rate write: the divider recomputes the tick length in microseconds, input held off meanwhile.
//  Reset: synchronous, active low; clears the task count and reloads 2000 Hz.
//  A stalled result stays in the output register; input waits until it leaves.
module periodic_tick_task_dispatcher_top #(
    parameter int SLOT_COUNT = ptd_pkg::SLOT_COUNT_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [ptd_pkg::S_DATA_W-1:0] s_tdata,   // period_us, handler_id, context_tag
    input  logic                         s_tuser,   // cmd
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [ptd_pkg::M_DATA_W-1:0] m_tdata,   // fire_mask, slot_index, active_count
    output logic [ptd_pkg::STATUS_W-1:0] m_tuser,   // status
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ptd_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import ptd_pkg::*;

    localparam int CNT_W = $clog2(SLOT_COUNT + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SCAN,
        S_DECIDE
    } state_t;

    state_t               state_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     scan_reg;
    logic [RATE_W-1:0]    rate_reg;
    logic [US_W-1:0]      us_tick_reg;
    logic                 cfg_busy_reg;
    ptd_key_t             key_reg;
    logic [RELOAD_W-1:0]  counter_reg;
    logic                 sat_reg;

    logic                 m_valid_reg;
    logic [MASK_W-1:0]    out_mask_reg;
    status_t              out_status_reg;
    logic [SLOT_W-1:0]    out_slot_reg;
    logic [ACTIVE_W-1:0]  out_count_reg;

    logic [PERIOD_W-1:0]  s_period;
    logic [HANDLER_W-1:0] s_handler;
    logic [CONTEXT_W-1:0] s_context;
    logic                 s_accept;
    logic                 out_free;
    logic                 cfg_sel;
    logic [RATE_W-1:0]    rate_eff;
    logic                 tick_en;
    logic                 reg_start;
    logic                 wr_en;
    logic                 dup;
    logic                 full;
    logic [CNT_W-1:0]     count_inc;
    logic [RELOAD_W-1:0]  x_sat;

    ptd_div_hs_t          div_hs;
    logic [PERIOD_W-1:0]  div_dividend;
    logic [DSH_W-1:0]     div_dsh;
    logic [STEP_W-1:0]    div_last;
    logic [US_W-1:0]      div_quo;

    logic [SLOT_COUNT-1:0]       fire_vec;
    logic [SLOT_COUNT:0]         hit_chain;
    logic [SLOT_COUNT+MASK_W-1:0] fire_pad;
    logic [CNT_W+ACTIVE_W-1:0]   count_pad;
    logic [CNT_W+ACTIVE_W-1:0]   inc_pad;

    assign s_period  = s_tdata[PERIOD_W-1:0];
    assign s_handler = s_tdata[PERIOD_W+HANDLER_W-1:PERIOD_W];
    assign s_context = s_tdata[PERIOD_W+HANDLER_W+CONTEXT_W-1:PERIOD_W+HANDLER_W];

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && !cfg_busy_reg && out_free;
    assign s_accept = s_tvalid && s_tready;
    assign tick_en  = s_accept && (s_tuser == CMD_TICK);
    assign reg_start = s_accept && (s_tuser == CMD_REGISTER) && (s_handler != '0);

    assign pready  = 1'b1;
    assign cfg_sel = psel && penable && pwrite && pready && (paddr == ADDR_TICK_RATE);
    assign prdata  = (paddr == ADDR_TICK_RATE) ? {{(32-RATE_W){1'b0}}, rate_reg} : 32'd0;
    assign rate_eff = (pwdata[RATE_W-1:0] == '0) ? RATE_W'(1) : pwdata[RATE_W-1:0];

    assign div_hs.start = cfg_sel || reg_start;
    assign div_dividend = cfg_sel ? PERIOD_W'(US_PER_SECOND) : s_period;
    assign div_dsh      = cfg_sel ? {rate_eff, {(DSH_W-RATE_W){1'b0}}}
                                  : DSH_W'({us_tick_reg, 6'b0});
    assign div_last     = cfg_sel ? CFG_LAST_STEP : REG_LAST_STEP;

    ptd_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_hs.start),
        .dividend  (div_dividend),
        .dsh_init  (div_dsh),
        .last_step (div_last),
        .done      (div_hs.done),
        .quotient  (div_quo)
    );

    assign x_sat = sat_reg ? PERIOD_MAX : div_quo[RELOAD_W-1:0];

    assign hit_chain[0] = 1'b0;
    assign dup  = hit_chain[SLOT_COUNT];
    assign full = (count_reg == CNT_W'(SLOT_COUNT));
    assign wr_en = (state_reg == S_DECIDE) && out_free && !dup && !full;
    assign count_inc = count_reg + CNT_W'(1);

    for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_slot
        ptd_ctl_t ctl;
        assign ctl.tick   = tick_en;
        assign ctl.wr     = wr_en && (count_reg == CNT_W'(i));
        assign ctl.active = CNT_W'(i) < count_reg;

        ptd_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ctl),
            .key        (key_reg),
            .wr_counter (counter_reg),
            .hit_in     (hit_chain[i]),
            .hit_out    (hit_chain[i+1]),
            .fire       (fire_vec[i])
        );
    end

    assign fire_pad  = {{MASK_W{1'b0}}, fire_vec};
    assign count_pad = {{ACTIVE_W{1'b0}}, count_reg};
    assign inc_pad   = {{ACTIVE_W{1'b0}}, count_inc};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            scan_reg     <= '0;
            rate_reg     <= RATE_W'(RATE_RESET);
            us_tick_reg  <= US_W'(US_TICK_RESET);
            cfg_busy_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_sel) begin
                rate_reg     <= pwdata[RATE_W-1:0];
                cfg_busy_reg <= 1'b1;
            end
            if (cfg_busy_reg && div_hs.done) begin
                us_tick_reg  <= div_quo;
                cfg_busy_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        key_reg.handler     <= s_handler;
                        key_reg.context_tag <= s_context;
                        sat_reg <= {3'b0, s_period} >= {us_tick_reg, 7'b0};
                        if (s_tuser == CMD_TICK) begin
                            m_valid_reg    <= 1'b1;
                            out_mask_reg   <= fire_pad[MASK_W-1:0];
                            out_status_reg <= ST_TICK;
                            out_slot_reg   <= '0;
                            out_count_reg  <= count_pad[ACTIVE_W-1:0];
                        end else if (s_handler == '0) begin
                            m_valid_reg    <= 1'b1;
                            out_mask_reg   <= '0;
                            out_status_reg <= ST_NULL;
                            out_slot_reg   <= '0;
                            out_count_reg  <= count_pad[ACTIVE_W-1:0];
                        end else begin
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (div_hs.done) begin
                        counter_reg    <= x_sat;
                        key_reg.reload <= (x_sat == '0) ? RELOAD_W'(1) : x_sat;
                        scan_reg       <= '0;
                        state_reg      <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (scan_reg == CNT_W'(SLOT_COUNT - 1)) begin
                        state_reg <= S_DECIDE;
                    end else begin
                        scan_reg <= scan_reg + CNT_W'(1);
                    end
                end
                S_DECIDE: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        out_mask_reg <= '0;
                        state_reg    <= S_IDLE;
                        if (dup) begin
                            out_status_reg <= ST_DUPLICATE;
                            out_slot_reg   <= '0;
                            out_count_reg  <= count_pad[ACTIVE_W-1:0];
                        end else if (full) begin
                            out_status_reg <= ST_FULL;
                            out_slot_reg   <= '0;
                            out_count_reg  <= count_pad[ACTIVE_W-1:0];
                        end else begin
                            out_status_reg <= ST_REGISTERED;
                            out_slot_reg   <= count_pad[SLOT_W-1:0];
                            out_count_reg  <= inc_pad[ACTIVE_W-1:0];
                            count_reg      <= count_inc;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {1'b0, out_count_reg, out_slot_reg, out_mask_reg};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(SLOT_COUNT))
        else $error("task count above slot count");

    a_ready_not_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !cfg_busy_reg && !div_hs.done)
        else $error("input ready while divider busy");

    a_write_room: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("slot write without count advance");

    a_div_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        div_hs.done |-> (state_reg == S_DIV) || cfg_busy_reg)
        else $error("divider result with no consumer");

    a_mask_tick_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (out_status_reg != ST_TICK) |-> out_mask_reg == '0)
        else $error("fire mask set on a registration result");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking bench for the periodic tick task dispatcher: directed and random beats.
module tb_top;
    import ptd_pkg::*;

    localparam int NUM_SLOTS        = SLOT_COUNT_DEF;
    localparam int MAX_IDLE         = 14;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int PERIOD_TOP       = 9999999;
    localparam int PHASE_BEATS      = 250;
    localparam int REPORT_LIMIT     = 10;
    localparam int SETTLE_CYCLES    = 40;

    typedef struct packed {
        logic [MASK_W-1:0]   fire_mask;
        status_t             status;
        logic [SLOT_W-1:0]   slot_index;
        logic [ACTIVE_W-1:0] active_count;
    } dispatch_result_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;   // period_us, handler_id, context_tag
    logic                s_tuser;   // cmd
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;   // fire_mask, slot_index, active_count
    logic [STATUS_W-1:0] m_tuser;   // status
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    logic [RATE_W-1:0]    model_rate;
    logic [HANDLER_W-1:0] model_handler [NUM_SLOTS];
    logic [CONTEXT_W-1:0] model_context [NUM_SLOTS];
    logic [RELOAD_W-1:0]  model_reload  [NUM_SLOTS];
    logic [7:0]           model_counter [NUM_SLOTS];
    int                   model_count;

    dispatch_result_t pending_results[$];
    int               error_count;
    bit               src_idle_on;
    bit               sink_idle_on;
    int               hold_request;

    periodic_tick_task_dispatcher_top #(
        .SLOT_COUNT(NUM_SLOTS)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int unsigned us_per_tick();
        int unsigned rate;
        int unsigned step_us;
        rate    = (model_rate == '0) ? 1 : int'(model_rate);
        step_us = US_PER_SECOND / rate;
        return (step_us == 0) ? 1 : step_us;
    endfunction

    function automatic dispatch_result_t predict_dispatch(input logic cmd,
                                                          input logic [PERIOD_W-1:0] period,
                                                          input logic [HANDLER_W-1:0] handler,
                                                          input logic [CONTEXT_W-1:0] ctx);
        dispatch_result_t r;
        int unsigned      ticks;
        int unsigned      start_cnt;
        int unsigned      reload;
        bit               dup;
        r     = '0;
        dup   = 1'b0;
        if (cmd == CMD_TICK) begin
            r.status = ST_TICK;
            for (int i = 0; i < model_count && i < NUM_SLOTS; i++) begin
                if (model_counter[i] <= 8'd1) begin
                    model_counter[i] = {1'b0, model_reload[i]};
                    r.fire_mask[i]   = 1'b1;
                end else begin
                    model_counter[i] = model_counter[i] - 8'd1;
                end
            end
        end else if (handler == '0) begin
            r.status = ST_NULL;
        end else begin
            ticks     = 32'(period) / us_per_tick();
            start_cnt = (ticks > int'(PERIOD_MAX)) ? int'(PERIOD_MAX) : ticks;
            reload    = (start_cnt < 1) ? 1 : start_cnt;
            for (int i = 0; i < model_count && i < NUM_SLOTS; i++) begin
                if (model_handler[i] == handler && model_context[i] == ctx &&
                    model_reload[i] == reload[RELOAD_W-1:0]) begin
                    dup = 1'b1;
                end
            end
            if (dup) begin
                r.status = ST_DUPLICATE;
            end else if (model_count >= NUM_SLOTS) begin
                r.status = ST_FULL;
            end else begin
                model_handler[model_count] = handler;
                model_context[model_count] = ctx;
                model_reload[model_count]  = reload[RELOAD_W-1:0];
                model_counter[model_count] = start_cnt[7:0];
                r.status     = ST_REGISTERED;
                r.slot_index = model_count[SLOT_W-1:0];
                model_count++;
            end
        end
        r.active_count = model_count[ACTIVE_W-1:0];
        return r;
    endfunction

    task automatic report_error(input string what, input logic [31:0] want,
                                input logic [31:0] got);
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
            $display("%0t mismatch %s: expected %0h, got %0h", $realtime, what, want, got);
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            report_error(what, want, got);
        end
    endtask

    task automatic send_beat(input logic cmd, input logic [PERIOD_W-1:0] period,
                             input logic [HANDLER_W-1:0] handler,
                             input logic [CONTEXT_W-1:0] ctx);
        int gap;
        gap = src_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        repeat (gap) begin
            @(negedge aclk) s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {ctx, handler, period};
        do @(posedge aclk); while (s_tready !== 1'b1);
        pending_results.push_back(predict_dispatch(cmd, period, handler, ctx));
    endtask

    task automatic tick();
        send_beat(CMD_TICK, PERIOD_W'($urandom_range(0, PERIOD_TOP)),
                  HANDLER_W'($urandom_range(0, 255)), CONTEXT_W'($urandom_range(0, 65535)));
    endtask

    task automatic register_task(input int unsigned period, input int unsigned handler,
                                 input int unsigned ctx);
        send_beat(CMD_REGISTER, period[PERIOD_W-1:0], handler[HANDLER_W-1:0],
                  ctx[CONTEXT_W-1:0]);
    endtask

    task automatic wait_idle();
        @(negedge aclk) s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_tick_rate(input logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_TICK_RATE;
        pwdata  <= value;
        @(negedge aclk) penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        model_rate = value[RATE_W-1:0];
        @(negedge aclk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk) penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        check_field("tick_rate_hz readback", {17'd0, model_rate}, prdata);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_null_and_empty();
        tick();
        register_task('h7FFFFF, 0, 'hFFFF);
        register_task(0, 0, 0);
    endtask

    task automatic test_register_and_duplicate();
        register_task(0, 1, 0);
        tick();
        register_task(499, 1, 0);
        register_task(PERIOD_TOP, 'hFF, 'hFFFF);
        register_task(1500, 1, 'h0001);
        register_task(500, 1, 0);
        repeat (4) tick();
    endtask

    task automatic test_rate_extremes();
        wait_idle();
        write_tick_rate(32'd100);
        register_task(30000, 'h80, 'h8000);
        wait_idle();
        write_tick_rate(32'd0);
        register_task('h7FFFFF, 2, 2);
        wait_idle();
        write_tick_rate(32'd32767);
        register_task(3810, 3, 'h00FF);
        wait_idle();
        write_tick_rate(32'hABCD_4E20);
        repeat (3) tick();
    endtask

    task automatic test_table_full();
        register_task(250, 4, 4);
        register_task(50, 5, 5);
        register_task(60, 6, 6);
        register_task(0, 1, 0);
        repeat (2) tick();
    endtask

    task automatic random_beat();
        int          pick;
        int          slot;
        int unsigned step_us;
        int unsigned period;
        pick    = $urandom_range(0, 99);
        step_us = us_per_tick();
        if (pick < 72) begin
            tick();
        end else if (pick < 78) begin
            register_task($urandom_range(0, PERIOD_TOP), 0, $urandom_range(0, 65535));
        end else if (pick < 90 && model_count > 0) begin
            slot   = $urandom_range(0, model_count - 1);
            period = 32'(model_reload[slot]) * step_us + $urandom_range(0, step_us - 1);
            if (period > PERIOD_TOP) begin
                period = PERIOD_TOP;
            end
            register_task(period, 32'(model_handler[slot]), 32'(model_context[slot]));
        end else if (pick < 95) begin
            register_task($urandom_range(0, 200) * step_us, $urandom_range(0, 255),
                          $urandom_range(0, 65535));
        end else begin
            register_task($urandom_range(0, PERIOD_TOP), $urandom_range(0, 255),
                          $urandom_range(0, 65535));
        end
    endtask

    task automatic test_random_phase(input logic [31:0] rate, input bit src_idle,
                                     input bit sink_idle, input bit squeeze);
        wait_idle();
        write_tick_rate(rate);
        src_idle_on  = src_idle;
        sink_idle_on = sink_idle;
        if (squeeze) begin
            hold_request = LONG_HOLD_CYCLES;
        end
        repeat (PHASE_BEATS) random_beat();
    endtask

    initial begin : result_check
        int gap;
        dispatch_result_t want;
        m_tready <= 1'b0;
        forever begin
            if (hold_request > 0) begin
                @(negedge aclk) m_tready <= 1'b0;
                repeat (hold_request - 1) @(negedge aclk);
                hold_request = 0;
            end
            gap = sink_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            repeat (gap) begin
                @(negedge aclk) m_tready <= 1'b0;
            end
            @(negedge aclk) m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            if (pending_results.size() == 0) begin
                report_error("unexpected result beat", 32'd0, 32'({m_tuser, m_tdata}));
            end else begin
                want = pending_results.pop_front();
                check_field("fire_mask", 32'(want.fire_mask), 32'(m_tdata[7:0]));
                check_field("slot_index", 32'(want.slot_index), 32'(m_tdata[10:8]));
                check_field("active_count", 32'(want.active_count), 32'(m_tdata[14:11]));
                check_field("tdata pad", 32'd0, 32'(m_tdata[15]));
                check_field("status", 32'(want.status), 32'(m_tuser));
            end
        end
    end

    initial begin
        aresetn      <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tuser      <= CMD_TICK;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= ADDR_TICK_RATE;
        pwdata       <= '0;
        error_count  = 0;
        hold_request = 0;
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        model_rate   = RATE_RESET[RATE_W-1:0];
        model_count  = 0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            model_handler[i] = '0;
            model_context[i] = '0;
            model_reload[i]  = '0;
            model_counter[i] = '0;
        end
        repeat (3) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        test_null_and_empty();
        test_register_and_duplicate();
        test_rate_extremes();
        test_table_full();
        test_random_phase(32'd100, 1'b1, 1'b1, 1'b0);
        test_random_phase(32'd20000, 1'b0, 1'b1, 1'b1);
        test_random_phase($urandom_range(100, 20000), 1'b1, 1'b0, 1'b0);
        test_random_phase($urandom_range(100, 20000), 1'b0, 1'b0, 1'b0);
        test_random_phase(32'd2000, 1'b1, 1'b1, 1'b0);
        test_random_phase($urandom_range(100, 20000), 1'b1, 1'b1, 1'b0);

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/ptd_pkg.sv
sv/ptd_cell.sv
sv/ptd_div.sv
sv/periodic_tick_task_dispatcher_top.sv
tb/tb_top.sv
